[hdl/pva_pkg.sv]
// Shared types and constants of the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_CHOKE    = 2'd2,
        OP_STATUS   = 2'd3
    } op_t;

    localparam logic [2:0] WF_SAW      = 3'd1;
    localparam logic [2:0] WF_TRIANGLE = 3'd2;

    localparam logic [1:0] PHASE_ZERO    = 2'd0;
    localparam logic [1:0] PHASE_QUARTER = 2'd1;
    localparam logic [1:0] PHASE_HALF    = 2'd2;

    localparam logic [7:0] NOTE_NONE = 8'hFF;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  note;
        logic [15:0] velocity;
        logic [2:0]  voice_sel;
        logic        running;
        logic        in_release;
        logic [15:0] level;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  chosen_voice;
        logic        start_voice;
        logic        phase_reset;
        logic [1:0]  start_phase;
        logic [15:0] velocity_out;
        logic [7:0]  release_mask;
        logic        is_choke;
    } result_t;

endpackage

`default_nettype wire

[hdl/pva_voice_mem.sv]
// Voice table memory with registered read and per-entry valid bits.
`default_nettype none

module pva_voice_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 59,
    parameter int AW = 3,
    parameter logic [WIDTH-1:0] INIT = '0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : INIT;

endmodule

`default_nettype wire

[hdl/pva_ctrl.sv]
// Sequencer that scans the voice table and performs allocation, release and status updates.
`default_nettype none

module pva_ctrl #(
    parameter int VOICES = 8,
    parameter int LEVEL_BITS = 16,
    parameter int IW = 3,
    parameter int ENTRY_W = 59
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire pva_pkg::cmd_t      cmd,
    input  wire logic [2:0]         waveform,
    output logic                    busy,
    output logic                    done,
    output pva_pkg::result_t        result,
    output logic                    mem_rd_en,
    output logic      [IW-1:0]      mem_rd_addr,
    input  wire logic [ENTRY_W-1:0] mem_rd_data,
    output logic                    mem_wr_en,
    output logic      [IW-1:0]      mem_wr_addr,
    output logic      [ENTRY_W-1:0] mem_wr_data
);

    import pva_pkg::*;

    localparam int CW = $clog2(VOICES + 1);
    localparam logic [CW-1:0] VOICES_C = CW'(VOICES);
    localparam logic [LEVEL_BITS-1:0] LVL_QUIET =
        LEVEL_BITS'(((1 << LEVEL_BITS) + 999) / 1000);

    typedef struct packed {
        logic                  on;
        logic [7:0]            note;
        logic [31:0]           age;
        logic                  live;
        logic                  rel;
        logic [LEVEL_BITS-1:0] lvl;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_COMMIT,
        S_REL_OUT,
        S_ST_RD,
        S_ST_WR
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  pend_reg;
    logic [IW-1:0]         pidx_reg;
    logic [IW-1:0]         addr_reg;
    logic                  match_found_reg;
    logic [IW-1:0]         match_idx_reg;
    logic                  free_found_reg;
    logic [IW-1:0]         free_idx_reg;
    logic                  rel_found_reg;
    logic [IW-1:0]         rel_idx_reg;
    logic [LEVEL_BITS-1:0] rel_lvl_reg;
    logic [IW-1:0]         old_idx_reg;
    logic [31:0]           old_age_reg;
    logic [VOICES-1:0]     mask_reg;
    logic [31:0]           age_counter_reg;
    logic                  done_reg;
    result_t               result_reg;

    entry_t                  e;
    entry_t                  wr_entry;
    logic                    release_all;
    logic                    hit;
    logic                    note_eq;
    logic [IW-1:0]           pick;
    logic [6:0]              sel_ext;
    logic                    sel_ok;
    logic [LEVEL_BITS+15:0]  lvl_ext;
    logic [VOICES+7:0]       mask_ext;
    logic [IW+2:0]           voice_ext;
    logic                    was_active;
    logic                    phase_rst;
    logic [1:0]              phase;

    always_comb
    begin
        e           = entry_t'(mem_rd_data);
        note_eq     = (e.note == cmd_reg.note);
        release_all = (cmd_reg.operation != OP_NOTE_OFF) || cmd_reg.note[7];
        hit         = e.on && (release_all || note_eq);
        sel_ext     = {4'b0, cmd.voice_sel};
        sel_ok      = (sel_ext < 7'(VOICES));
        lvl_ext     = {{LEVEL_BITS{1'b0}}, cmd_reg.level};
        mask_ext    = {8'b0, mask_reg};
        voice_ext   = {3'b0, addr_reg};
        was_active  = e.on && e.live;
        phase_rst   = !was_active || (e.lvl < LVL_QUIET);
        phase       = PHASE_ZERO;
        if (phase_rst && (waveform == WF_SAW))
        begin
            phase = PHASE_HALF;
        end
        else if (phase_rst && (waveform == WF_TRIANGLE))
        begin
            phase = PHASE_QUARTER;
        end

        if (match_found_reg)
        begin
            pick = match_idx_reg;
        end
        else if (free_found_reg)
        begin
            pick = free_idx_reg;
        end
        else if (rel_found_reg)
        begin
            pick = rel_idx_reg;
        end
        else
        begin
            pick = old_idx_reg;
        end

        mem_rd_en   = 1'b0;
        mem_rd_addr = cnt_reg[IW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = pidx_reg;
        wr_entry    = e;

        case (state_reg)
            S_SCAN:
            begin
                mem_rd_en = (cnt_reg < VOICES_C);
                if (pend_reg && (cmd_reg.operation != OP_NOTE_ON) && hit && e.live)
                begin
                    mem_wr_en    = 1'b1;
                    wr_entry.rel = 1'b1;
                end
            end
            S_PICK:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pick;
            end
            S_ST_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_reg;
            end
            S_ST_WR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = addr_reg;
                wr_entry.on   = e.on && cmd_reg.running;
                wr_entry.live = cmd_reg.running;
                wr_entry.rel  = cmd_reg.in_release;
                wr_entry.lvl  = lvl_ext[LEVEL_BITS-1:0];
            end
            S_COMMIT:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = addr_reg;
                wr_entry.on   = 1'b1;
                wr_entry.note = cmd_reg.note;
                wr_entry.age  = age_counter_reg;
                wr_entry.live = 1'b1;
                wr_entry.rel  = 1'b0;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
        mem_wr_data = wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            pidx_reg        <= '0;
            addr_reg        <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            rel_found_reg   <= 1'b0;
            rel_idx_reg     <= '0;
            rel_lvl_reg     <= '0;
            old_idx_reg     <= '0;
            old_age_reg     <= '0;
            mask_reg        <= '0;
            age_counter_reg <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg         <= cmd;
                        cnt_reg         <= '0;
                        pend_reg        <= 1'b0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        rel_found_reg   <= 1'b0;
                        mask_reg        <= '0;
                        if (cmd.operation == OP_STATUS)
                        begin
                            addr_reg <= sel_ext[IW-1:0];
                            if (sel_ok)
                            begin
                                state_reg <= S_ST_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= (cnt_reg < VOICES_C);
                    pidx_reg <= cnt_reg[IW-1:0];
                    if (cnt_reg < VOICES_C)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        if (cmd_reg.operation == OP_NOTE_ON)
                        begin
                            if (!match_found_reg && e.on && note_eq)
                            begin
                                match_found_reg <= 1'b1;
                                match_idx_reg   <= pidx_reg;
                            end
                            if (!free_found_reg && (!e.on || !e.live))
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= pidx_reg;
                            end
                            if (e.rel && (!rel_found_reg || (e.lvl < rel_lvl_reg)))
                            begin
                                rel_found_reg <= 1'b1;
                                rel_idx_reg   <= pidx_reg;
                                rel_lvl_reg   <= e.lvl;
                            end
                            if ((pidx_reg == '0) || (e.age < old_age_reg))
                            begin
                                old_idx_reg <= pidx_reg;
                                old_age_reg <= e.age;
                            end
                        end
                        else if (hit)
                        begin
                            mask_reg[pidx_reg] <= 1'b1;
                        end
                    end
                    if (cnt_reg == VOICES_C)
                    begin
                        state_reg <= (cmd_reg.operation == OP_NOTE_ON) ? S_PICK : S_REL_OUT;
                    end
                end
                S_PICK:
                begin
                    addr_reg  <= pick;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    done_reg                <= 1'b1;
                    result_reg              <= '0;
                    result_reg.chosen_voice <= voice_ext[2:0];
                    result_reg.start_voice  <= 1'b1;
                    result_reg.phase_reset  <= phase_rst;
                    result_reg.start_phase  <= phase;
                    result_reg.velocity_out <= cmd_reg.velocity;
                    age_counter_reg         <= age_counter_reg + 32'd1;
                    state_reg               <= S_IDLE;
                end
                S_REL_OUT:
                begin
                    done_reg                <= 1'b1;
                    result_reg              <= '0;
                    result_reg.release_mask <= mask_ext[7:0];
                    result_reg.is_choke     <= (cmd_reg.operation == OP_CHOKE);
                    state_reg               <= S_IDLE;
                end
                S_ST_RD:
                begin
                    state_reg <= S_ST_WR;
                end
                S_ST_WR:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/poly_voice_allocator_core.sv]
// Top level of the polyphonic voice allocator with voice stealing.
//
// A word is taken when start is high and busy is low; operation selects note on,
// note off, choke or an envelope status report for one voice.
// Note on, note off and choke each give one result word, marked by done for
// exactly one cycle; a status report gives none.
// The voice table sits in one memory with a registered read, scanned one voice
// per cycle; a note off or choke then passes the release output state before
// done, and a note on passes the pick and commit states.
// A status report keeps busy high for a read, modify and write of one entry.
// One word is worked on at a time; busy is low in the cycle that done is high,
// so the next word may be taken there. The user writes the waveform register
// through cfg_we and cfg_wdata only while idle; the block does not enforce it.
// Reset clears the waveform, the age counter and the voice table, whose entries
// read as free voices until first written.
// The receiver cannot stall: each result must be taken in its done cycle.
`default_nettype none

module poly_voice_allocator_core #(
    parameter int VOICES = 8,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  note,
    input  wire logic [15:0] velocity,
    input  wire logic [2:0]  voice_sel,
    input  wire logic        env_running,
    input  wire logic        env_in_release,
    input  wire logic [15:0] env_level,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,
    output logic             done,
    output logic [2:0]       chosen_voice,
    output logic             start_voice,
    output logic             phase_reset,
    output logic [1:0]       start_phase,
    output logic [15:0]      velocity_out,
    output logic [7:0]       release_mask,
    output logic             is_choke
);

    import pva_pkg::*;

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ENTRY_W = 1 + 8 + 32 + 1 + 1 + LEVEL_BITS;
    localparam logic [ENTRY_W-1:0] ENTRY_INIT = {1'b0, NOTE_NONE, {(ENTRY_W - 9){1'b0}}};

    logic [2:0]         waveform_reg;
    cmd_t               cmd;
    result_t            result;
    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= '0;
        end
        else if (cfg_we)
        begin
            waveform_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        cmd.operation  = op_t'(operation);
        cmd.note       = note;
        cmd.velocity   = velocity;
        cmd.voice_sel  = voice_sel;
        cmd.running    = env_running;
        cmd.in_release = env_in_release;
        cmd.level      = env_level;
    end

    pva_voice_mem #(
        .DEPTH (VOICES),
        .WIDTH (ENTRY_W),
        .AW    (IW),
        .INIT  (ENTRY_INIT)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    pva_ctrl #(
        .VOICES     (VOICES),
        .LEVEL_BITS (LEVEL_BITS),
        .IW         (IW),
        .ENTRY_W    (ENTRY_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .waveform    (waveform_reg),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    assign chosen_voice = result.chosen_voice;
    assign start_voice  = result.start_voice;
    assign phase_reset  = result.phase_reset;
    assign start_phase  = result.start_phase;
    assign velocity_out = result.velocity_out;
    assign release_mask = result.release_mask;
    assign is_choke     = result.is_choke;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while sequencer still busy");

    a_status_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_STATUS)) |=> !done)
        else $error("status report produced a result word");

    a_note_on_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && start_voice) |-> ((release_mask == 8'd0) && !is_choke))
        else $error("note-on result carries a release mask");

    a_phase_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !phase_reset) |-> (start_phase == PHASE_ZERO))
        else $error("start phase given without phase reset");

endmodule

`default_nettype wire

[sim/pva_checker.sv]
// Checker for the voice allocator: predicts each result word and compares it with the block.
module pva_checker
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  note,
    input  logic [15:0] velocity,
    input  logic [2:0]  voice_sel,
    input  logic        env_running,
    input  logic        env_in_release,
    input  logic [15:0] env_level,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        done,
    input  logic [2:0]  chosen_voice,
    input  logic        start_voice,
    input  logic        phase_reset,
    input  logic [1:0]  start_phase,
    input  logic [15:0] velocity_out,
    input  logic [7:0]  release_mask,
    input  logic        is_choke,
    output int          mismatch_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVOICE = 8;
    localparam logic [15:0] QUIET_LEVEL = 16'd66;

    logic [2:0]  waveform;
    logic        voice_on [NVOICE];
    logic [7:0]  voice_note [NVOICE];
    logic [31:0] voice_age [NVOICE];
    logic [31:0] age_count;
    logic        env_live [NVOICE];
    logic        env_rel [NVOICE];
    logic [15:0] env_lvl [NVOICE];

    result_t due_results [$];
    int errors = 0;

    function automatic int choose_voice(logic [7:0] nt);
        int best;
        bit found;
        logic [15:0] low;
        best = 0;
        found = 0;
        low = '0;
        for (int i = 0; i < NVOICE; i++)
            if (voice_on[i] && voice_note[i] == nt)
                return i;
        for (int i = 0; i < NVOICE; i++)
            if (!voice_on[i] || !env_live[i])
                return i;
        for (int i = 0; i < NVOICE; i++)
        begin
            if (env_rel[i] && (!found || env_lvl[i] < low))
            begin
                low = env_lvl[i];
                best = i;
                found = 1;
            end
        end
        if (found)
            return best;
        best = 0;
        for (int i = 1; i < NVOICE; i++)
            if (voice_age[i] < voice_age[best])
                best = i;
        return best;
    endfunction

    function automatic logic [7:0] release_voices(bit every, logic [7:0] nt);
        logic [7:0] mask;
        mask = '0;
        for (int i = 0; i < NVOICE; i++)
        begin
            if (voice_on[i] && (every || voice_note[i] == nt))
            begin
                mask[i] = 1'b1;
                if (env_live[i])
                    env_rel[i] = 1'b1;
            end
        end
        return mask;
    endfunction

    function automatic bit allocate_word(output result_t res);
        int v;
        bit idle_voice;
        res = '0;
        case (op_t'(operation))
            OP_STATUS:
            begin
                env_live[voice_sel] = env_running;
                env_rel[voice_sel] = env_in_release;
                env_lvl[voice_sel] = env_level;
                if (!env_running)
                    voice_on[voice_sel] = 1'b0;
                return 0;
            end
            OP_NOTE_ON:
            begin
                v = choose_voice(note);
                idle_voice = !(voice_on[v] && env_live[v]);
                res.chosen_voice = 3'(v);
                res.start_voice = 1'b1;
                res.phase_reset = idle_voice || env_lvl[v] < QUIET_LEVEL;
                if (res.phase_reset && waveform == WF_SAW)
                    res.start_phase = PHASE_HALF;
                else if (res.phase_reset && waveform == WF_TRIANGLE)
                    res.start_phase = PHASE_QUARTER;
                else
                    res.start_phase = PHASE_ZERO;
                res.velocity_out = velocity;
                voice_note[v] = note;
                voice_age[v] = age_count;
                age_count = age_count + 32'd1;
                voice_on[v] = 1'b1;
                env_live[v] = 1'b1;
                env_rel[v] = 1'b0;
            end
            OP_NOTE_OFF:
                res.release_mask = release_voices(note[7], note);
            default:
            begin
                res.release_mask = release_voices(1'b1, note);
                res.is_choke = 1'b1;
            end
        endcase
        return 1;
    endfunction

    task automatic report(string what, result_t want, result_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected voice %0d start %0b reset %0b phase %0d vel %h mask %h choke %0b, got voice %0d start %0b reset %0b phase %0d vel %h mask %h choke %0b",
                     $realtime, what, want.chosen_voice, want.start_voice, want.phase_reset,
                     want.start_phase, want.velocity_out, want.release_mask, want.is_choke,
                     got.chosen_voice, got.start_voice, got.phase_reset, got.start_phase,
                     got.velocity_out, got.release_mask, got.is_choke);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            waveform = '0;
            age_count = '0;
            for (int i = 0; i < NVOICE; i++)
            begin
                voice_on[i] = 1'b0;
                voice_note[i] = NOTE_NONE;
                voice_age[i] = '0;
                env_live[i] = 1'b0;
                env_rel[i] = 1'b0;
                env_lvl[i] = '0;
            end
            due_results.delete();
        end
        else
        begin
            if (done)
            begin
                got.chosen_voice = chosen_voice;
                got.start_voice = start_voice;
                got.phase_reset = phase_reset;
                got.start_phase = start_phase;
                got.velocity_out = velocity_out;
                got.release_mask = release_mask;
                got.is_choke = is_choke;
                if (due_results.size() == 0)
                    report("result word with none due", '0, got);
                else
                begin
                    want = due_results.pop_front();
                    if (want.chosen_voice !== got.chosen_voice
                        || want.start_voice !== got.start_voice
                        || want.phase_reset !== got.phase_reset
                        || want.start_phase !== got.start_phase
                        || want.velocity_out !== got.velocity_out
                        || want.release_mask !== got.release_mask
                        || want.is_choke !== got.is_choke)
                        report("wrong result word", want, got);
                end
            end
            if (cfg_we)
                waveform = cfg_wdata;
            if (start && !busy)
                if (allocate_word(want))
                    due_results.push_back(want);
        end
        pending <= due_results.size();
        mismatch_count <= errors;
    end

endmodule

[sim/tb_poly_voice_allocator_core.sv]
// Testbench top for the voice allocator: drives words and the waveform register, gives the verdict.
module tb_poly_voice_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pva_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS = 150;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [7:0]  note;
    logic [15:0] velocity;
    logic [2:0]  voice_sel;
    logic        env_running;
    logic        env_in_release;
    logic [15:0] env_level;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        done;
    logic [2:0]  chosen_voice;
    logic        start_voice;
    logic        phase_reset;
    logic [1:0]  start_phase;
    logic [15:0] velocity_out;
    logic [7:0]  release_mask;
    logic        is_choke;
    int          mismatch_count;
    int          pending;
    int          stall_cycles;

    logic [7:0]  note_pool [12];
    logic [2:0]  wf_order [8] = '{3'd0, 3'd2, 3'd7, 3'd4, 3'd3, 3'd1, 3'd5, 3'd6};

    poly_voice_allocator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .note          (note),
        .velocity      (velocity),
        .voice_sel     (voice_sel),
        .env_running   (env_running),
        .env_in_release(env_in_release),
        .env_level     (env_level),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .chosen_voice  (chosen_voice),
        .start_voice   (start_voice),
        .phase_reset   (phase_reset),
        .start_phase   (start_phase),
        .velocity_out  (velocity_out),
        .release_mask  (release_mask),
        .is_choke      (is_choke)
    );

    pva_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .note          (note),
        .velocity      (velocity),
        .voice_sel     (voice_sel),
        .env_running   (env_running),
        .env_in_release(env_in_release),
        .env_level     (env_level),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .chosen_voice  (chosen_voice),
        .start_voice   (start_voice),
        .phase_reset   (phase_reset),
        .start_phase   (start_phase),
        .velocity_out  (velocity_out),
        .release_mask  (release_mask),
        .is_choke      (is_choke),
        .mismatch_count(mismatch_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(op_t op, logic [7:0] nt, logic [15:0] vel, logic [2:0] vsel,
                             logic run, logic rel, logic [15:0] lvl);
        @(negedge clk);
        start <= 1'b1;
        operation <= op;
        note <= nt;
        velocity <= vel;
        voice_sel <= vsel;
        env_running <= run;
        env_in_release <= rel;
        env_level <= lvl;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic play(logic [7:0] nt, logic [15:0] vel);
        send_word(OP_NOTE_ON, nt, vel, 3'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic stop(logic [7:0] nt);
        send_word(OP_NOTE_OFF, nt, 16'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                  16'($urandom));
    endtask

    task automatic choke();
        send_word(OP_CHOKE, 8'($urandom), 16'($urandom), 3'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom));
    endtask

    task automatic report_env(logic [2:0] v, logic run, logic rel, logic [15:0] lvl);
        send_word(OP_STATUS, 8'($urandom), 16'($urandom), v, run, rel, lvl);
    endtask

    task automatic idle_for(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain(bit settle);
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_waveform(logic [2:0] wf);
        drain(1);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= wf;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int r;
        logic [7:0] nt;
        logic [15:0] lvl;
        r = $urandom_range(0, 99);
        nt = note_pool[$urandom_range(0, 11)];
        if (r < 40)
        begin
            if ($urandom_range(0, 9) == 0)
                nt = ($urandom_range(0, 3) == 0) ? NOTE_NONE : 8'($urandom_range(0, 127));
            play(nt, 16'($urandom));
        end
        else if (r < 60)
        begin
            if ($urandom_range(0, 9) == 0)
                nt = NOTE_NONE;
            else if ($urandom_range(0, 19) == 0)
                nt = 8'($urandom_range(0, 127));
            stop(nt);
        end
        else if (r < 65)
            choke();
        else
        begin
            case ($urandom_range(0, 3))
                0: lvl = 16'($urandom_range(0, 100));
                1: lvl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: lvl = 16'($urandom);
            endcase
            report_env(3'($urandom), $urandom_range(0, 3) != 0, 1'($urandom), lvl);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_NOTE_ON;
        note = '0;
        velocity = '0;
        voice_sel = '0;
        env_running = 1'b0;
        env_in_release = 1'b0;
        env_level = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_waveform(WF_SAW);
        play(8'd0, 16'h0000);
        play(8'd127, 16'hFFFF);
        play(8'd0, 16'h1234);
        report_env(3'd0, 1'b1, 1'b0, 16'hFFFF);
        play(8'd0, 16'hABCD);
        stop(8'd0);
        stop(NOTE_NONE);
        stop(8'd55);
        choke();
        report_env(3'd1, 1'b0, 1'b1, 16'h0000);
        for (int n = 10; n < 17; n++)
            play(8'(n), 16'(n * 4099));
        play(8'd20, 16'h5555);
        report_env(3'd3, 1'b1, 1'b1, 16'h0040);
        report_env(3'd5, 1'b1, 1'b1, 16'h0040);
        report_env(3'd6, 1'b1, 1'b0, 16'h0042);
        play(8'd30, 16'hAAAA);
        play(8'd31, 16'h0001);
        play(8'd32, 16'h8000);
        report_env(3'd7, 1'b0, 1'b0, 16'h0000);
        play(8'd33, 16'h7FFF);

        for (int p = 0; p < 8; p++)
        begin
            set_waveform(wf_order[p]);
            for (int i = 0; i < 12; i++)
                note_pool[i] = 8'($urandom_range(0, 127));
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p != 2 && $urandom_range(0, 99) < 30)
                    idle_for($urandom_range(1, 15));
                if ($urandom_range(0, 49) == 0)
                    drain(0);
                random_word();
            end
        end

        drain(1);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[poly_voice_allocator_core.f]
hdl/pva_pkg.sv
hdl/pva_voice_mem.sv
hdl/pva_ctrl.sv
hdl/poly_voice_allocator_core.sv
sim/pva_checker.sv
sim/tb_poly_voice_allocator_core.sv
